// File: design/fss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fss_pkg;

  // Number of bisection halvings, one pipelined step each
  localparam int BisectSteps = 16;

  // Quotient bits of the per-point travel time / elapsed time divide
  localparam int DivBits = 24;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_VISC_RATIO     = 3'd0,
    CFG_CONN_WATER_SAT = 3'd1,
    CFG_RESID_OIL_SAT  = 3'd2,
    CFG_ELAPSED_TIME   = 3'd3,
    CFG_FRONT_SAT      = 3'd4,
    CFG_FRONT_SLOPE    = 3'd5
  } fss_cfg_idx_e;

  // Region codes of a point
  typedef enum logic [1:0] {
    REGION_INLET  = 2'd0,
    REGION_FRONT  = 2'd1,
    REGION_AHEAD  = 2'd2,
    REGION_BEHIND = 2'd3
  } fss_region_e;

  // Rock/fluid settings needed by the slope evaluation
  typedef struct packed {
    logic [23:0] visc;
    logic [15:0] swc;
    logic [15:0] sor;
  } fss_cfg_t;

  // One point travelling down the pipeline
  typedef struct packed {
    logic        valid;
    logic        last;
    fss_region_e region;
    logic        ok;      // threshold k1 usable (time nonzero, k1 within slope range)
    logic [23:0] k1;      // smallest slope whose product beats the travel time
    logic [16:0] x0;
    logic [16:0] x1;
    logic [16:0] xm;
  } fss_item_t;

endpackage

`default_nettype wire

// File: design/fss_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Point input channel
interface fss_pt_if ();
  logic               valid;
  logic               ready;
  logic signed [31:0] travel_time;
  logic               last_in;

  modport source (output valid, travel_time, last_in, input ready);
  modport sink   (input valid, travel_time, last_in, output ready);
endinterface

// Saturation result channel
interface fss_sat_if ();
  logic        valid;
  logic        ready;
  logic [15:0] saturation;
  logic [1:0]  region;
  logic        last_out;

  modport source (output valid, saturation, region, last_out, input ready);
  modport sink   (input valid, saturation, region, last_out, output ready);
endinterface

`default_nettype wire

// File: design/fss_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One bisection halving: midpoint, fractional flow slope test, bracket update.
// Seven register stages; the last one is the output register.
module fss_step
  import fss_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire fss_cfg_t  cfg_i,
  input  wire fss_item_t item_i,
  output fss_item_t      item_o
);

  localparam int Stages = 6;

  fss_item_t it_q [Stages];
  fss_item_t item1;
  fss_item_t nxt7;

  // stage 1: midpoint and saturation offsets
  logic [17:0]        sum1;
  logic [16:0]        xm1;
  logic signed [18:0] u1_d, w1_d, u1_q, w1_q;

  assign sum1 = 18'(item_i.x0) + 18'(item_i.x1);
  assign xm1  = sum1[17:1];
  assign u1_d = signed'({2'b00, xm1}) - signed'({3'b000, cfg_i.swc});
  assign w1_d = 19'sd65536 - signed'({2'b00, xm1}) - signed'({3'b000, cfg_i.sor});

  always_comb begin
    item1    = item_i;
    item1.xm = xm1;
  end

  // stage 2: products of the offsets
  logic signed [37:0] uw2_d, uu2_d, ww2_d, uw2_q;
  logic [32:0]        uu2_q, ww2_q;

  assign uw2_d = u1_q * w1_q;
  assign uu2_d = u1_q * u1_q;
  assign ww2_d = w1_q * w1_q;

  // stage 3: numerator magnitude and weighted u^2
  logic signed [17:0] ds;
  logic [17:0]        ds_mag;
  logic [37:0]        uw_mag;
  logic [33:0]        m_prod;
  logic [56:0]        vuu_prod;
  logic [17:0]        m3_q;
  logic [40:0]        vuu3_q;
  logic [32:0]        ww3_q;
  logic               neg3_q;

  assign ds       = 18'sd65536 - signed'({2'b00, cfg_i.swc}) - signed'({2'b00, cfg_i.sor});
  assign ds_mag   = ds[17] ? 18'(-ds) : 18'(ds);
  assign uw_mag   = uw2_q[37] ? 38'(-uw2_q) : 38'(uw2_q);
  assign m_prod   = 34'(uw_mag[32:16]) * 34'(ds_mag[16:0]);
  assign vuu_prod = 57'(cfg_i.visc) * 57'(uu2_q);

  // stage 4: numerator and denominator root
  logic [41:0] num_prod;
  logic [41:0] d4;
  logic [42:0] num4_q;
  logic [25:0] d16_4_q;
  logic        neg4_q;

  assign num_prod = 42'(cfg_i.visc) * 42'(m3_q);
  assign d4       = 42'(vuu3_q) + 42'(ww3_q);

  // stage 5: denominator
  logic [51:0] den5_q;
  logic [42:0] num5_q;
  logic        neg5_q;

  // stage 6: threshold times denominator, in two halves
  logic [49:0] plo6_q, phi6_q;
  logic [42:0] num6_q;
  logic        neg6_q, nz6_q, dz6_q;

  // stage 7: slope(xm) * t > tau test and bracket update
  logic [75:0] prod7, np7;
  logic        go7;

  assign prod7 = {phi6_q, 26'd0} + 76'(plo6_q);
  assign np7   = 76'({num6_q, 16'd0});
  assign go7   = it_q[5].ok && !neg6_q && nz6_q && (dz6_q || (np7 >= prod7));

  always_comb begin
    nxt7 = it_q[5];
    if (go7) begin
      nxt7.x1 = it_q[5].xm;
    end else begin
      nxt7.x0 = it_q[5].xm;
    end
  end

  // item control path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Stages; i++) it_q[i] <= '0;
      item_o <= '0;
    end else if (en_i) begin
      it_q[0] <= item1;
      for (int i = 1; i < Stages; i++) it_q[i] <= it_q[i-1];
      item_o <= nxt7;
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_q    <= u1_d;
      w1_q    <= w1_d;
      uw2_q   <= uw2_d;
      uu2_q   <= uu2_d[32:0];
      ww2_q   <= ww2_d[32:0];
      m3_q    <= m_prod[33:16];
      vuu3_q  <= vuu_prod[56:16];
      ww3_q   <= ww2_q;
      neg3_q  <= uw2_q[37] != ds[17];
      num4_q  <= {num_prod, 1'b0};
      d16_4_q <= d4[41:16];
      neg4_q  <= neg3_q;
      den5_q  <= 52'(d16_4_q) * 52'(d16_4_q);
      num5_q  <= num4_q;
      neg5_q  <= neg4_q;
      plo6_q  <= 50'(it_q[4].k1) * 50'(den5_q[25:0]);
      phi6_q  <= 50'(it_q[4].k1) * 50'(den5_q[51:26]);
      num6_q  <= num5_q;
      neg6_q  <= neg5_q;
      nz6_q   <= num5_q != '0;
      dz6_q   <= den5_q == '0;
    end
  end

endmodule

`default_nettype wire

// File: design/front_saturation_solver_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Buckley-Leverett front saturation solver. Each point's travel time is
// classified against front_slope * elapsed_time (inlet, at front, ahead,
// behind) and, behind the front, the water saturation is found by sixteen
// bisection halvings between 1 - Sor and front_sat. The block is fully
// pipelined: one point per cycle unless a result waits at the output. Its
// stages: input register, classify, 24 divider stages forming the slope
// threshold floor(tau * 2^16 / t) + 1, sixteen 7-stage bisection steps,
// output register. Results leave in input order. The whole pipeline
// advances together and holds while a result waits at the output.
// Configuration registers may only be written with no point in flight.
module front_saturation_solver_unit
  import fss_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fss_pt_if.sink     pt_i,
  fss_sat_if.source  sat_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam logic [23:0] ViscReset   = 24'd65536;
  localparam logic [15:0] SwcReset    = 16'd13107;
  localparam logic [15:0] SorReset    = 16'd13107;
  localparam logic [31:0] TimeReset   = 32'd65536;
  localparam logic [15:0] FsatReset   = 16'd40899;
  localparam logic [23:0] FslopeReset = 24'd132071;

  // configuration registers
  logic [23:0] visc_q;
  logic [15:0] swc_q, sor_q, fsat_q;
  logic [31:0] time_q;
  logic [23:0] fslope_q;
  fss_cfg_t    cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visc_q   <= ViscReset;
      swc_q    <= SwcReset;
      sor_q    <= SorReset;
      time_q   <= TimeReset;
      fsat_q   <= FsatReset;
      fslope_q <= FslopeReset;
    end else if (cfg_we_i) begin
      case (fss_cfg_idx_e'(cfg_idx_i))
        CFG_VISC_RATIO:     visc_q   <= cfg_data_i[23:0];
        CFG_CONN_WATER_SAT: swc_q    <= cfg_data_i[15:0];
        CFG_RESID_OIL_SAT:  sor_q    <= cfg_data_i[15:0];
        CFG_ELAPSED_TIME:   time_q   <= cfg_data_i;
        CFG_FRONT_SAT:      fsat_q   <= cfg_data_i[15:0];
        CFG_FRONT_SLOPE:    fslope_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{visc: visc_q, swc: swc_q, sor: sor_q};

  // front position product, follows the configuration
  logic [55:0] front_prod_q;

  always_ff @(posedge clk_i) begin
    front_prod_q <= 56'(fslope_q) * 56'(time_q);
  end

  // global advance: the pipeline moves unless a result is stuck at the output
  logic pipe_en;
  logic sat_valid_q;

  assign pipe_en    = !sat_valid_q || sat_o.ready;
  assign pt_i.ready = pipe_en;

  // stage A: input register
  logic               a_valid_q, a_last_q;
  logic signed [31:0] a_tau_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_last_q  <= 1'b0;
    end else if (pipe_en) begin
      a_valid_q <= pt_i.valid;
      a_last_q  <= pt_i.last_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) a_tau_q <= pt_i.travel_time;
  end

  // stage B: region classification and divider setup
  logic        tau_pos;
  logic [46:0] tshift;
  logic        b_kbad;
  fss_item_t   b_item;

  assign tau_pos = !a_tau_q[31] && (a_tau_q != '0);
  assign tshift  = {a_tau_q[30:0], 16'd0};
  assign b_kbad  = (time_q == '0) || (56'(tshift) >= {time_q, 24'd0});

  always_comb begin
    b_item       = '0;
    b_item.valid = a_valid_q;
    b_item.last  = a_last_q;
    if (!tau_pos) begin
      b_item.region = REGION_INLET;
    end else if (56'(tshift) == front_prod_q) begin
      b_item.region = REGION_FRONT;
    end else if (56'(tshift) > front_prod_q) begin
      b_item.region = REGION_AHEAD;
    end else begin
      b_item.region = REGION_BEHIND;
    end
    b_item.x0 = 17'h10000 - 17'(sor_q);
    b_item.x1 = 17'(fsat_q);
    b_item.xm = b_item.x0;
  end

  // restoring divider, one quotient bit per stage, MSB first
  fss_item_t   dv_q   [DivBits+1];
  logic [46:0] rem_q  [DivBits+1];
  logic [23:0] quo_q  [DivBits+1];
  logic        kbad_q [DivBits+1];
  logic [55:0] dvs    [1:DivBits];
  logic        ge_div [1:DivBits];
  logic [46:0] rem_d  [1:DivBits];
  logic [23:0] quo_d  [1:DivBits];

  always_comb begin
    for (int j = 1; j <= DivBits; j++) begin
      dvs[j]    = 56'(time_q) << (DivBits - j);
      ge_div[j] = 56'(rem_q[j-1]) >= dvs[j];
      rem_d[j]  = ge_div[j] ? 47'(56'(rem_q[j-1]) - dvs[j]) : rem_q[j-1];
      quo_d[j]  = {quo_q[j-1][22:0], ge_div[j]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= DivBits; j++) dv_q[j] <= '0;
    end else if (pipe_en) begin
      dv_q[0] <= b_item;
      for (int j = 1; j <= DivBits; j++) dv_q[j] <= dv_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      rem_q[0]  <= tshift;
      quo_q[0]  <= '0;
      kbad_q[0] <= b_kbad;
      for (int j = 1; j <= DivBits; j++) begin
        rem_q[j]  <= rem_d[j];
        quo_q[j]  <= quo_d[j];
        kbad_q[j] <= kbad_q[j-1];
      end
    end
  end

  // bisection chain
  fss_item_t chain [BisectSteps+1];

  always_comb begin
    chain[0]    = dv_q[DivBits];
    chain[0].k1 = quo_q[DivBits] + 24'd1;
    chain[0].ok = !kbad_q[DivBits] && (quo_q[DivBits] != '1);
  end

  for (genvar k = 0; k < BisectSteps; k++) begin : g_step
    fss_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (pipe_en),
      .cfg_i  (cfg),
      .item_i (chain[k]),
      .item_o (chain[k+1])
    );
  end

  // output register
  fss_item_t   fin;
  logic [15:0] sat_d, sat_q;
  fss_region_e region_q;
  logic        last_q;

  assign fin = chain[BisectSteps];

  always_comb begin
    case (fin.region)
      REGION_INLET:  sat_d = (sor_q == '0) ? 16'hFFFF : 16'(17'h10000 - 17'(sor_q));
      REGION_FRONT:  sat_d = fsat_q;
      REGION_AHEAD:  sat_d = swc_q;
      REGION_BEHIND: sat_d = fin.xm[16] ? 16'hFFFF : fin.xm[15:0];
      default:       sat_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_valid_q <= 1'b0;
    end else if (pipe_en) begin
      sat_valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sat_q    <= sat_d;
      region_q <= fin.region;
      last_q   <= fin.last;
    end
  end

  assign sat_o.valid      = sat_valid_q;
  assign sat_o.saturation = sat_q;
  assign sat_o.region     = region_q;
  assign sat_o.last_out   = last_q;

  // divider leaves a remainder below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[DivBits].valid && !kbad_q[DivBits] |-> 56'(rem_q[DivBits]) < 56'(time_q))
    else $error("divider remainder not below elapsed time");

  // a stall freezes the end of the bisection chain
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(chain[BisectSteps]))
    else $error("bisection chain moved during stall");

  // a new result comes only from a valid point at the chain end
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sat_o.valid) |-> $past(chain[BisectSteps].valid))
    else $error("result without a point");

  // a usable threshold is never zero
  a_k1_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[0].valid && chain[0].ok |-> chain[0].k1 != '0)
    else $error("zero slope threshold");

endmodule

`default_nettype wire
